// ----- rtl/core/rmq_pkg.sv -----
// shared widths, constants and pipeline payload types for the matrix to quaternion block
package rmq_pkg;

  // element and intermediate widths
  localparam int MW      = 16;             // matrix element and quaternion component
  localparam int TW      = 18;             // signed candidate and off-diagonal combos
  localparam int AW      = 17;             // magnitude of one vector component
  localparam int SQW     = 2 * AW;         // one squared magnitude
  localparam int SUMW    = SQW + 2;        // sum of four squares
  localparam int PRESH   = 8;              // scale of the sum before the root
  localparam int XS      = SUMW + PRESH;   // root operand
  localparam int NW      = XS / 2;         // root width, one bit per stage
  localparam int RW      = NW + 3;         // root remainder
  localparam int DW      = NW + 1;         // divisor, twice the root
  localparam int NUMSH   = 19;             // numerator scale
  localparam int XW      = AW + NUMSH + 1; // numerator and division remainder
  localparam int QW      = 18;             // raw quotient, one bit per stage
  localparam int CW      = DW + QW - 1;    // compare width of a division step

  localparam int ONE_Q14 = 16384;

  // signed-magnitude vector before normalisation
  typedef struct packed {
    logic [3:0]         neg;
    logic [3:0][AW-1:0] mag;
  } rmq_vec_t;

  // one stage of the square root pipeline
  typedef struct packed {
    logic [XS-1:0] x;
    logic [RW-1:0] rem;
    logic [NW-1:0] root;
    rmq_vec_t      vec;
  } rmq_sq_t;

  // one stage of the division pipeline
  typedef struct packed {
    logic [DW-1:0]         d;
    logic [3:0][XW-1:0]    rem;
    logic [3:0][QW-1:0]    q;
    logic [3:0]            neg;
  } rmq_dv_t;

endpackage

// ----- rtl/core/rotation_matrix_to_quaternion.sv -----
// top level: rotation matrix to unit quaternion, fully pipelined
//
// Input channel: in_valid / in_stall with nine signed Q1.14 matrix elements
// in_m00 .. in_m22. Output channel: out_valid / out_stall with the unit
// quaternion out_q_w, out_q_x, out_q_y, out_q_z in signed Q1.14, each
// saturated to plus or minus one. A transaction completes on a rising edge
// with valid high and stall low.
// Throughput is one matrix per cycle while in_stall is low. The stages from input
// transaction to out_valid are four front stages (candidates, pick, squares,
// sum), 22 square root stages at one root bit each, one numerator stage and
// 18 divider stages at one quotient bit each, and the output register.
// When out_stall holds a result, the pipeline keeps moving as long as its
// last stage is empty, so bubbles close up and inputs are still taken; once
// the last stage holds a transaction too, the whole pipeline freezes and
// in_stall rises. Nothing is dropped or repeated.
// Synchronous active-low reset clears every valid bit; no transaction is
// in flight afterwards and the datapath registers need no reset.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [MW-1:0] in_m00,
  input  logic [MW-1:0] in_m01,
  input  logic [MW-1:0] in_m02,
  input  logic [MW-1:0] in_m10,
  input  logic [MW-1:0] in_m11,
  input  logic [MW-1:0] in_m12,
  input  logic [MW-1:0] in_m20,
  input  logic [MW-1:0] in_m21,
  input  logic [MW-1:0] in_m22,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [MW-1:0] out_q_w,
  output logic [MW-1:0] out_q_x,
  output logic [MW-1:0] out_q_y,
  output logic [MW-1:0] out_q_z
);

  localparam logic [QW-1:0] QMAX = QW'(ONE_Q14);

  logic               adv;
  logic               out_ld;
  logic [8:0][MW-1:0] m;
  logic               x_valid;
  logic [XS-1:0]      x;
  rmq_vec_t           vec_f;
  logic               root_valid;
  logic [NW-1:0]      root;
  rmq_vec_t           vec_s;
  logic               q_valid;
  logic [3:0][QW-1:0] q;
  logic [3:0]         q_neg;
  logic [3:0][MW-1:0] res_nxt;
  logic [3:0][MW-1:0] res_r;
  logic               out_valid_r;

  // pipeline moves unless the output is held and the last stage is full
  assign out_ld   = !out_valid_r || !out_stall;
  assign adv      = out_ld || !q_valid;
  assign in_stall = !adv;

  assign m = {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};

  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .m        (m),
    .x_valid  (x_valid),
    .x        (x),
    .vec      (vec_f)
  );

  rmq_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (x_valid),
    .x          (x),
    .vec_in     (vec_f),
    .root_valid (root_valid),
    .root       (root),
    .vec_out    (vec_s)
  );

  rmq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (root_valid),
    .root     (root),
    .vec      (vec_s),
    .q_valid  (q_valid),
    .q        (q),
    .q_neg    (q_neg)
  );

  // saturate to one and restore the sign
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [MW-1:0] mag;
      mag        = (q[i] > QMAX) ? MW'(QMAX) : MW'(q[i]);
      res_nxt[i] = q_neg[i] ? -mag : mag;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_q_w   = res_r[0];
  assign out_q_x   = res_r[1];
  assign out_q_y   = res_r[2];
  assign out_q_z   = res_r[3];

  // full pipeline behind a held result takes no new transaction
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && q_valid) |-> in_stall)
    else $error("input taken while pipeline is frozen");

  // a held result is not lost while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(res_r)))
    else $error("held result changed under stall");

  // every component stays within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (($signed(out_q_w) <= ONE_Q14) && ($signed(out_q_w) >= -ONE_Q14) &&
                     ($signed(out_q_x) <= ONE_Q14) && ($signed(out_q_x) >= -ONE_Q14) &&
                     ($signed(out_q_y) <= ONE_Q14) && ($signed(out_q_y) >= -ONE_Q14) &&
                     ($signed(out_q_z) <= ONE_Q14) && ($signed(out_q_z) >= -ONE_Q14)))
    else $error("quaternion component out of range");

  // reset leaves no transaction pending
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

// ----- rtl/core/rmq_front.sv -----
// front end: candidates, largest pick, unnormalised vector and its squared length
module rmq_front
  import rmq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [8:0][MW-1:0]   m,
  output logic                 x_valid,
  output logic [XS-1:0]        x,
  output rmq_vec_t             vec
);

  localparam logic [1:0] PICK_W = 2'd0;
  localparam logic [1:0] PICK_X = 2'd1;
  localparam logic [1:0] PICK_Y = 2'd2;
  localparam logic [1:0] PICK_Z = 2'd3;

  localparam logic signed [TW-1:0] ONE_T = TW'(ONE_Q14);

  logic signed [TW-1:0] e [9];
  logic signed [TW-1:0] t_nxt [4];
  logic signed [TW-1:0] c_nxt [6];
  logic signed [TW-1:0] t_r [4];
  logic signed [TW-1:0] c_r [6];
  logic                 v0_r, v1_r, v2_r, v3_r;
  logic [1:0]           pick;
  logic signed [TW-1:0] best;
  logic signed [TW-1:0] sv [4];
  rmq_vec_t             vec_nxt;
  rmq_vec_t             vec1_r, vec2_r, vec3_r;
  logic [3:0][SQW-1:0]  sq_r;
  logic [XS-1:0]        x_r;

  // sign extension of the elements
  genvar gi;
  generate
    for (gi = 0; gi < 9; gi++) begin : g_ext
      assign e[gi] = TW'($signed(m[gi]));
    end
  endgenerate

  // stage 0: candidates and off-diagonal sums and differences
  always_comb begin
    t_nxt[0] = ONE_T + e[0] + e[4] + e[8];
    t_nxt[1] = ONE_T + e[0] - e[4] - e[8];
    t_nxt[2] = ONE_T - e[0] + e[4] - e[8];
    t_nxt[3] = ONE_T - e[0] - e[4] + e[8];
    c_nxt[0] = e[7] - e[5]; // m21 - m12
    c_nxt[1] = e[2] - e[6]; // m02 - m20
    c_nxt[2] = e[3] - e[1]; // m10 - m01
    c_nxt[3] = e[3] + e[1]; // m10 + m01
    c_nxt[4] = e[2] + e[6]; // m02 + m20
    c_nxt[5] = e[7] + e[5]; // m21 + m12
  end

  // stage 1: largest candidate, ties to the lowest index, then sign and magnitude
  always_comb begin
    pick = PICK_W;
    best = t_r[0];
    if (t_r[1] > best) begin
      pick = PICK_X;
      best = t_r[1];
    end
    if (t_r[2] > best) begin
      pick = PICK_Y;
      best = t_r[2];
    end
    if (t_r[3] > best) begin
      pick = PICK_Z;
      best = t_r[3];
    end
    case (pick)
      PICK_W: begin
        sv[0] = t_r[0]; sv[1] = c_r[0]; sv[2] = c_r[1]; sv[3] = c_r[2];
      end
      PICK_X: begin
        sv[0] = c_r[0]; sv[1] = t_r[1]; sv[2] = c_r[3]; sv[3] = c_r[4];
      end
      PICK_Y: begin
        sv[0] = c_r[1]; sv[1] = c_r[3]; sv[2] = t_r[2]; sv[3] = c_r[5];
      end
      default: begin
        sv[0] = c_r[2]; sv[1] = c_r[4]; sv[2] = c_r[5]; sv[3] = t_r[3];
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      vec_nxt.neg[i] = sv[i][TW-1];
      vec_nxt.mag[i] = sv[i][TW-1] ? AW'(-sv[i]) : AW'(sv[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r    <= t_nxt;
      c_r    <= c_nxt;
      vec1_r <= vec_nxt;
      vec2_r <= vec1_r;
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= SQW'(vec1_r.mag[i]) * SQW'(vec1_r.mag[i]);
      end
      vec3_r <= vec2_r;
      x_r    <= {SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]) + SUMW'(sq_r[3]),
                 {PRESH{1'b0}}};
    end
  end

  assign x_valid = v3_r;
  assign x       = x_r;
  assign vec     = vec3_r;

endmodule

// ----- rtl/core/rmq_sqrt.sv -----
// integer square root, one result bit per pipeline stage
module rmq_sqrt
  import rmq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [XS-1:0] x,
  input  rmq_vec_t      vec_in,
  output logic          root_valid,
  output logic [NW-1:0] root,
  output rmq_vec_t      vec_out
);

  logic    valid_r [NW];
  rmq_sq_t st_r    [NW];
  logic    vin     [NW];
  rmq_sq_t sin     [NW];
  rmq_sq_t snxt    [NW];

  genvar gk;
  generate
    for (gk = 0; gk < NW; gk++) begin : g_stage
      localparam int P = NW - 1 - gk;
      logic [RW-1:0] rem_sh;
      logic [RW-1:0] trial;

      // stage input
      if (gk == 0) begin : g_first
        assign vin[gk]      = in_valid;
        assign sin[gk].x    = x;
        assign sin[gk].rem  = '0;
        assign sin[gk].root = '0;
        assign sin[gk].vec  = vec_in;
      end else begin : g_next
        assign vin[gk] = valid_r[gk-1];
        assign sin[gk] = st_r[gk-1];
      end

      // bring down two operand bits and try the next root bit
      always_comb begin
        rem_sh   = {sin[gk].rem[RW-3:0], sin[gk].x[2*P+1 -: 2]};
        trial    = RW'({sin[gk].root, 2'b01});
        snxt[gk] = sin[gk];
        if (rem_sh >= trial) begin
          snxt[gk].rem  = rem_sh - trial;
          snxt[gk].root = {sin[gk].root[NW-2:0], 1'b1};
        end else begin
          snxt[gk].rem  = rem_sh;
          snxt[gk].root = {sin[gk].root[NW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[gk] <= 1'b0;
        end else if (adv) begin
          valid_r[gk] <= vin[gk];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          st_r[gk] <= snxt[gk];
        end
      end
    end
  endgenerate

  assign root_valid = valid_r[NW-1];
  assign root       = st_r[NW-1].root;
  assign vec_out    = st_r[NW-1].vec;

endmodule

// ----- rtl/core/rmq_div.sv -----
// four-lane restoring divider, one quotient bit per pipeline stage
module rmq_div
  import rmq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [NW-1:0]      root,
  input  rmq_vec_t           vec,
  output logic               q_valid,
  output logic [3:0][QW-1:0] q,
  output logic [3:0]         q_neg
);

  logic    prep_valid_r;
  rmq_dv_t prep_r;
  rmq_dv_t prep_nxt;
  logic    valid_r [QW];
  rmq_dv_t st_r    [QW];
  logic    vin     [QW];
  rmq_dv_t sin     [QW];
  rmq_dv_t snxt    [QW];

  // numerator |v| * 2^19 + N for rounding, divisor 2N
  always_comb begin
    prep_nxt.d   = {root, 1'b0};
    prep_nxt.neg = vec.neg;
    for (int i = 0; i < 4; i++) begin
      prep_nxt.rem[i] = XW'({vec.mag[i], {NUMSH{1'b0}}}) + XW'(root);
      prep_nxt.q[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (adv) begin
      prep_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_r <= prep_nxt;
    end
  end

  genvar gk;
  generate
    for (gk = 0; gk < QW; gk++) begin : g_stage
      localparam int S = QW - 1 - gk;
      logic [CW-1:0] dsh;

      if (gk == 0) begin : g_first
        assign vin[gk] = prep_valid_r;
        assign sin[gk] = prep_r;
      end else begin : g_next
        assign vin[gk] = valid_r[gk-1];
        assign sin[gk] = st_r[gk-1];
      end

      // compare against the shifted divisor and subtract where it fits
      always_comb begin
        dsh      = CW'(sin[gk].d) << S;
        snxt[gk] = sin[gk];
        for (int i = 0; i < 4; i++) begin
          if (CW'(sin[gk].rem[i]) >= dsh) begin
            snxt[gk].rem[i] = XW'(CW'(sin[gk].rem[i]) - dsh);
            snxt[gk].q[i]   = {sin[gk].q[i][QW-2:0], 1'b1};
          end else begin
            snxt[gk].q[i]   = {sin[gk].q[i][QW-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[gk] <= 1'b0;
        end else if (adv) begin
          valid_r[gk] <= vin[gk];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          st_r[gk] <= snxt[gk];
        end
      end
    end
  endgenerate

  assign q_valid = valid_r[QW-1];
  assign q       = st_r[QW-1].q;
  assign q_neg   = st_r[QW-1].neg;

endmodule
